@@ hw/rtl/cfa_pkg.sv @@
// ----------------------------------------------------------------------------
// cfa_pkg: shared types and constants of the custom float ALU
// Word layout, opcodes, the request record passed from front to back, and
// the compare codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cfa_pkg;

    // Word layout: exponent in the top bits, significand below.
    localparam int EXP_BITS = 4;
    localparam int SIG_BITS = 28;
    localparam int WORD_W   = EXP_BITS + SIG_BITS;

    // Raw quotient and product width.
    localparam int T_BITS   = 2 * SIG_BITS;
    localparam int BL_W     = $clog2(T_BITS + 1);

    // Divider: one quotient bit per step, a few steps per stage.
    localparam int DIV_STEPS  = T_BITS;
    localparam int DIV_PER    = 2;
    localparam int DIV_STAGES = DIV_STEPS / DIV_PER;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH_DEF = 2;

    // Opcodes.
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_NEG = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_EQ  = 3'd5,
        OP_CMP = 3'd6
    } t_op;

    // Work class chosen by the front.
    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2,
        K_DIRECT = 2'd3
    } t_kind;

    // Compare result codes.
    localparam logic signed [1:0] ORD_EQ = 2'sb00;
    localparam logic signed [1:0] ORD_GT = 2'sb01;
    localparam logic signed [1:0] ORD_LT = 2'sb11;

    // Request record as it travels through the queue.
    typedef struct packed {
        t_kind              kind;
        logic [WORD_W-1:0]  a;
        logic [WORD_W-1:0]  b;
        logic [WORD_W-1:0]  word;
        logic               eq;
        logic signed [1:0]  ord;
    } t_req;

endpackage

`default_nettype wire

@@ hw/rtl/cfa_front.sv @@
// ----------------------------------------------------------------------------
// cfa_front: request intake and classification
// Registers each request, sorts it into add, multiply, divide or a direct
// result, and finishes negate, equality and compare right here.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_front import cfa_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_req_type,
    input  wire logic [WORD_W-1:0]  i_operand_a,
    input  wire logic [WORD_W-1:0]  i_operand_b,
    output logic                    o_push,
    output t_req                    o_req,
    input  wire logic               i_q_full
);

    logic  r_valid;
    t_req  r_req;
    t_req  n_req;
    logic  [WORD_W-1:0] neg_b;
    logic  accept;

    // A held request leaves as soon as the queue has room.
    assign o_push  = r_valid && !i_q_full;
    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_req   = r_req;

    // Negation keeps the exponent and negates the significand.
    assign neg_b = {i_operand_b[WORD_W-1:SIG_BITS],
                    SIG_BITS'(~i_operand_b[SIG_BITS-1:0] + 1'b1)};

    // Classification.
    always_comb begin
        n_req      = '0;
        n_req.kind = K_DIRECT;
        n_req.a    = i_operand_a;
        n_req.b    = i_operand_b;
        unique case (i_req_type)
            OP_ADD: n_req.kind = K_ADD;
            OP_SUB: begin
                n_req.kind = K_ADD;
                n_req.b    = neg_b;
            end
            OP_NEG: n_req.word = neg_b;
            OP_MUL: n_req.kind = K_MUL;
            OP_DIV: n_req.kind = K_DIV;
            OP_EQ:  n_req.eq   = (i_operand_a == i_operand_b);
            OP_CMP: begin
                if (i_operand_a == i_operand_b) begin
                    n_req.ord = ORD_EQ;
                end else if (i_operand_a[WORD_W-1:SIG_BITS]
                             != i_operand_b[WORD_W-1:SIG_BITS]) begin
                    n_req.ord = (i_operand_a[WORD_W-1:SIG_BITS]
                                 > i_operand_b[WORD_W-1:SIG_BITS]) ? ORD_GT : ORD_LT;
                end else begin
                    n_req.ord = (i_operand_a[SIG_BITS-1:0]
                                 > i_operand_b[SIG_BITS-1:0]) ? ORD_GT : ORD_LT;
                end
            end
            default: n_req = n_req;
        endcase
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_req <= n_req;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cfa_queue.sv @@
// ----------------------------------------------------------------------------
// cfa_queue: request queue between front and back
// A small register queue so that front and back can each stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_queue import cfa_pkg::*; #(
    parameter int DEPTH = Q_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_req  i_req,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_req       o_req
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_req           r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_req   = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cfa_back.sv @@
// ----------------------------------------------------------------------------
// cfa_back: execution pipeline
// Aligns and sums, multiplies, divides in a pipelined restoring divider,
// then renormalizes by leading-bit position and packs the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_back import cfa_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  wire t_req               i_req,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [WORD_W-1:0]       o_result_word,
    output logic                    o_is_equal,
    output logic signed [1:0]       o_order
);

    // Stage record inside the pipeline.
    typedef struct packed {
        t_kind                kind;
        logic [EXP_BITS-1:0]  base;
        logic                 neg;
        logic                 asign;
        logic                 dz;
        logic [T_BITS-1:0]    t;
        logic [SIG_BITS-1:0]  rem;
        logic [SIG_BITS-1:0]  na;
        logic [SIG_BITS-1:0]  dvs;
        logic [WORD_W-1:0]    word;
        logic                 eq;
        logic signed [1:0]    ord;
    } t_bk;

    localparam logic [WORD_W-1:0] DZ_POS =
        {1'b0, {(EXP_BITS-1){1'b1}}, 1'b0, {(SIG_BITS-1){1'b1}}};
    localparam logic [WORD_W-1:0] DZ_NEG =
        {1'b0, {(EXP_BITS-1){1'b1}}, 1'b1, {(SIG_BITS-1){1'b0}}};

    // Arithmetic right shift, where a result of minus one becomes zero.
    function automatic logic [SIG_BITS-1:0] align_z(
        input logic signed [SIG_BITS-1:0] x,
        input logic [EXP_BITS:0] d
    );
        logic signed [SIG_BITS-1:0] y;
        y = x >>> d;
        return (y == '1) ? '0 : y;
    endfunction

    // A few restoring division steps.
    function automatic t_bk div_steps(input t_bk s);
        t_bk r;
        logic [SIG_BITS:0] r2;
        r = s;
        if (s.kind == K_DIV) begin
            for (int k = 0; k < DIV_PER; k++) begin
                r2 = {r.rem, r.na[SIG_BITS-1]};
                r.na = {r.na[SIG_BITS-2:0], 1'b0};
                if (r2 >= {1'b0, r.dvs}) begin
                    r2 = r2 - {1'b0, r.dvs};
                    r.t = {r.t[T_BITS-2:0], 1'b1};
                end else begin
                    r.t = {r.t[T_BITS-2:0], 1'b0};
                end
                r.rem = r2[SIG_BITS-1:0];
            end
        end
        return r;
    endfunction

    // Position of the leading one, zero for zero.
    function automatic logic [BL_W-1:0] bitlen(input logic [T_BITS-1:0] v);
        logic [BL_W-1:0] n;
        n = '0;
        for (int i = 0; i < T_BITS; i++) begin
            if (v[i]) begin
                n = BL_W'(i + 1);
            end
        end
        return n;
    endfunction

    logic                  adv;
    logic                  r_v [DIV_STAGES+1];
    t_bk                   r_st [DIV_STAGES+1];
    t_bk                   n_st0;
    logic                  r_n1_v;
    t_bk                   r_n1;
    logic [BL_W-1:0]       r_bl;
    logic [BL_W-1:0]       n_bl;
    logic                  r_out_v;
    logic [WORD_W-1:0]     r_word;
    logic                  r_eq;
    logic signed [1:0]     r_ord;
    logic [WORD_W-1:0]     n_word;

    logic signed [EXP_BITS-1:0] ea, eb;
    logic signed [SIG_BITS-1:0] sa, sb;
    logic [SIG_BITS-1:0]        al_a, al_b, ma, mb;
    logic [SIG_BITS:0]          sum;

    // The whole pipeline moves when the output register can take a result.
    assign adv     = !r_out_v || !i_stall;
    assign o_pop   = adv && !i_q_empty;
    assign o_valid = r_out_v;
    assign o_result_word = r_word;
    assign o_is_equal    = r_eq;
    assign o_order       = r_ord;

    // Entry stage: alignment and sum, magnitude product, divider setup.
    always_comb begin
        ea = i_req.a[WORD_W-1:SIG_BITS];
        eb = i_req.b[WORD_W-1:SIG_BITS];
        sa = i_req.a[SIG_BITS-1:0];
        sb = i_req.b[SIG_BITS-1:0];
        al_a = sa;
        al_b = sb;
        ma = sa[SIG_BITS-1] ? SIG_BITS'(-sa) : sa;
        mb = sb[SIG_BITS-1] ? SIG_BITS'(-sb) : sb;

        n_st0       = '0;
        n_st0.kind  = i_req.kind;
        n_st0.word  = i_req.word;
        n_st0.eq    = i_req.eq;
        n_st0.ord   = i_req.ord;
        n_st0.neg   = sa[SIG_BITS-1] ^ sb[SIG_BITS-1];
        n_st0.asign = sa[SIG_BITS-1];
        n_st0.dz    = (mb == '0);
        n_st0.na    = ma;
        n_st0.dvs   = mb;
        n_st0.base  = i_req.a[WORD_W-1:SIG_BITS];

        if (ea > eb) begin
            al_b = align_z(sb, (EXP_BITS+1)'({ea[EXP_BITS-1], ea} - {eb[EXP_BITS-1], eb}));
        end else if (eb > ea) begin
            al_a = align_z(sa, (EXP_BITS+1)'({eb[EXP_BITS-1], eb} - {ea[EXP_BITS-1], ea}));
            n_st0.base = i_req.b[WORD_W-1:SIG_BITS];
        end
        sum = {al_a[SIG_BITS-1], al_a} + {al_b[SIG_BITS-1], al_b};

        unique case (i_req.kind)
            K_ADD: n_st0.t = T_BITS'(sum);
            K_MUL: begin
                n_st0.t    = T_BITS'(ma) * T_BITS'(mb);
                n_st0.base = EXP_BITS'(i_req.a[WORD_W-1:SIG_BITS]
                             + i_req.b[WORD_W-1:SIG_BITS] - EXP_BITS'(SIG_BITS - 1));
            end
            K_DIV: begin
                n_st0.base = EXP_BITS'(i_req.a[WORD_W-1:SIG_BITS]
                             - i_req.b[WORD_W-1:SIG_BITS] - EXP_BITS'(1));
            end
            K_DIRECT: n_st0.t = '0;
            default: n_st0.t = '0;
        endcase
    end

    // Leading-bit search over the sum or the raw product or quotient.
    // For a negative sum the inverted significand bits are searched, kept
    // at significand width before they are widened.
    always_comb begin
        if (r_st[DIV_STAGES].kind == K_ADD) begin
            n_bl = bitlen({{(T_BITS-SIG_BITS){1'b0}},
                           (r_st[DIV_STAGES].t[SIG_BITS]
                            ? ~r_st[DIV_STAGES].t[SIG_BITS-1:0]
                            : r_st[DIV_STAGES].t[SIG_BITS-1:0])});
        end else begin
            n_bl = bitlen(r_st[DIV_STAGES].t);
        end
    end

    // Renormalize, apply the sign and pack.
    always_comb begin
        logic [SIG_BITS-1:0] u;
        logic [EXP_BITS-1:0] re;
        re = EXP_BITS'(r_n1.base + EXP_BITS'(r_bl) - EXP_BITS'(SIG_BITS - 1));
        if (r_n1.kind == K_ADD) begin
            if (r_bl == BL_W'(SIG_BITS)) begin
                u = r_n1.t[SIG_BITS:1];
            end else begin
                u = SIG_BITS'(r_n1.t[SIG_BITS-1:0] << (BL_W'(SIG_BITS - 1) - r_bl));
            end
        end else begin
            if (r_bl > BL_W'(SIG_BITS - 1)) begin
                u = SIG_BITS'(r_n1.t >> (r_bl - BL_W'(SIG_BITS - 1)));
            end else begin
                u = SIG_BITS'(r_n1.t << (BL_W'(SIG_BITS - 1) - r_bl));
            end
            if (r_n1.neg) begin
                u = SIG_BITS'(~u + 1'b1);
            end
        end
        unique case (r_n1.kind)
            K_ADD:    n_word = (r_n1.t[SIG_BITS:0] == '0) ? '0 : {re, u};
            K_MUL:    n_word = {re, u};
            K_DIV:    n_word = r_n1.dz ? (r_n1.asign ? DZ_NEG : DZ_POS) : {re, u};
            K_DIRECT: n_word = r_n1.word;
            default:  n_word = r_n1.word;
        endcase
    end

    // Valid bits of every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
            r_n1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_v[0] <= !i_q_empty;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_n1_v  <= r_v[DIV_STAGES];
            r_out_v <= r_n1_v;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st[0] <= n_st0;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_st[k] <= div_steps(r_st[k-1]);
            end
            r_n1   <= r_st[DIV_STAGES];
            r_bl   <= n_bl;
            r_word <= n_word;
            r_eq   <= r_n1.eq;
            r_ord  <= r_n1.ord;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/custom_float_alu.sv @@
// Throughput: one request per cycle while nothing stalls; the divider is a
// pipeline of two quotient bits per stage, which sets the depth of the back
// pipeline.
// Reset: synchronous, active low; clears all valid bits and the queue count.
// The front and the back are parted by a short queue and stall independently.
// ----------------------------------------------------------------------------
// custom_float_alu: arithmetic unit for a packed exponent/significand word
// Front classifies requests, a queue buffers them, the back executes them.
// ----------------------------------------------------------------------------
`default_nettype none

module custom_float_alu import cfa_pkg::*; #(
    parameter int Q_DEPTH = Q_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_req_type,
    input  wire logic [WORD_W-1:0]  i_operand_a,
    input  wire logic [WORD_W-1:0]  i_operand_b,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [WORD_W-1:0]       o_result_word,
    output logic                    o_is_equal,
    output logic signed [1:0]       o_order
);

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;
    t_req  f_req;
    t_req  q_req;

    // Request intake.
    cfa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req_type  (i_req_type),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_push      (push),
        .o_req       (f_req),
        .i_q_full    (q_full)
    );

    // Queue between front and back.
    cfa_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (f_req),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_req   (q_req)
    );

    // Execution pipeline.
    cfa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_req         (q_req),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_word (o_result_word),
        .o_is_equal    (o_is_equal),
        .o_order       (o_order)
    );

endmodule

`default_nettype wire
